// File: sv/cvdc_pkg.sv
// Shared types and constants for the CO2 valve duty controller.
`default_nettype none

package cvdc_pkg;

    localparam int DUTY_WINDOW   = 50;
    localparam int DUTY_W        = $clog2(DUTY_WINDOW + 1);
    localparam int PERCENT_SCALE = 100;
    localparam int PROD_W        = $clog2(DUTY_WINDOW * PERCENT_SCALE + 1);

    localparam int PCT_W     = 7;
    localparam int DIV_BIT_W = 3;
    localparam int TICK_W    = 32;
    localparam int CO2_W     = 16;
    localparam int HUM_W     = 15;
    localparam int TEMP_W    = 16;
    localparam int CO2_REP_W = 17;
    localparam int TH_REP_W  = 16;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [DIV_BIT_W-1:0] DIV_TOP_BIT      = DIV_BIT_W'(PCT_W - 1);
    localparam logic [TH_REP_W-1:0]  FAULT_REPORT_TH  = 16'hFF9D;
    localparam logic [CO2_REP_W-1:0] FAULT_REPORT_CO2 = 17'h1FFFF;

    localparam logic [CO2_W-1:0]  TARGET_RESET     = 16'd0;
    localparam logic [TICK_W-1:0] MIN_OPEN_RESET   = 32'd2000;
    localparam logic [TICK_W-1:0] MIN_CLOSED_RESET = 32'd10000;

    typedef enum logic [1:0] {
        REG_CO2_SETPOINT = 2'd0,
        REG_MIN_OPEN     = 2'd1,
        REG_MIN_CLOSED   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CO2_W-1:0]  co2_setpoint;
        logic [TICK_W-1:0] min_open_ticks;
        logic [TICK_W-1:0] min_closed_ticks;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 capture;
        logic                 eval;
        logic                 div_step;
        logic [DIV_BIT_W-1:0] div_bit;
        logic                 out_load;
    } cmd_t;

    typedef struct packed {
        logic decide;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: sv/cvdc_apb_regs.sv
// APB configuration registers: CO2 target and minimum open/closed times.
`default_nettype none

module cvdc_apb_regs
    import cvdc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.co2_setpoint     <= TARGET_RESET;
            cfg_reg.min_open_ticks   <= MIN_OPEN_RESET;
            cfg_reg.min_closed_ticks <= MIN_CLOSED_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CO2_SETPOINT: cfg_reg.co2_setpoint     <= pwdata[CO2_W-1:0];
                REG_MIN_OPEN:     cfg_reg.min_open_ticks   <= pwdata[TICK_W-1:0];
                REG_MIN_CLOSED:   cfg_reg.min_closed_ticks <= pwdata[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CO2_SETPOINT: prdata = DATA_W'(cfg_reg.co2_setpoint);
            REG_MIN_OPEN:     prdata = DATA_W'(cfg_reg.min_open_ticks);
            REG_MIN_CLOSED:   prdata = DATA_W'(cfg_reg.min_closed_ticks);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/cvdc_ctrl.sv
// Sequencer: capture, evaluate, bit-serial duty divide, result hand-off.
`default_nettype none

module cvdc_ctrl
    import cvdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t               state_reg, state_next;
    logic [DIV_BIT_W-1:0] bit_reg, bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_next     = bit_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.div_bit  = bit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.decide)
                begin
                    bit_next   = DIV_TOP_BIT;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                    state_next = ST_FINISH;
                else
                    bit_next = bit_reg - 1'b1;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/cvdc_datapath.sv
// Datapath: valve timing state, duty estimate, restoring divider, result register.
`default_nettype none

module cvdc_datapath
    import cvdc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cfg_t                    cfg,
    input  wire cmd_t                    cmd,
    output status_t                      status,
    input  wire logic [TICK_W-1:0]       now_tick,
    input  wire logic [CO2_W-1:0]        co2_reading,
    input  wire logic                    co2_fault,
    input  wire logic [HUM_W-1:0]        humidity_reading,
    input  wire logic                    humidity_fault,
    input  wire logic signed [TEMP_W-1:0] temperature_reading,
    input  wire logic                    temperature_fault,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         valve_drive,
    output logic signed [CO2_REP_W-1:0]  co2_report,
    output logic signed [TH_REP_W-1:0]   humidity_report,
    output logic signed [TH_REP_W-1:0]   temperature_report,
    output logic [PCT_W-1:0]             valve_percent
);

    // captured request
    logic [TICK_W-1:0] now_reg;
    logic [CO2_W-1:0]  co2_reg;
    logic              co2_fault_reg;
    logic [HUM_W-1:0]  hum_reg;
    logic              hum_fault_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic              temp_fault_reg;

    // controller state
    logic              valve_open_reg, valve_open_next;
    logic [TICK_W-1:0] opened_at_reg, opened_at_next;
    logic [TICK_W-1:0] closed_at_reg, closed_at_next;
    logic [DUTY_W-1:0] duty_sum_reg, duty_sum_next;
    logic [DUTY_W-1:0] duty_count_reg, duty_count_next;
    logic [PCT_W-1:0]  held_percent_reg, held_percent_next;

    // divider
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [PCT_W-1:0]  quo_reg, quo_next;

    logic              out_valid_reg;

    logic              open_elapsed, closed_elapsed, open_now, decide, div_hit;
    logic [PROD_W-1:0] trial;

    assign open_elapsed   = (now_reg - opened_at_reg) >= cfg.min_open_ticks;
    assign closed_elapsed = (now_reg - closed_at_reg) >= cfg.min_closed_ticks;
    assign open_now       = co2_reg < cfg.co2_setpoint;
    assign decide         = !co2_fault_reg && !valve_open_reg && closed_elapsed;

    assign trial   = PROD_W'(duty_count_reg) << cmd.div_bit;
    assign div_hit = rem_reg >= trial;

    assign status.decide   = decide;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        valve_open_next   = valve_open_reg;
        opened_at_next    = opened_at_reg;
        closed_at_next    = closed_at_reg;
        duty_sum_next     = duty_sum_reg;
        duty_count_next   = duty_count_reg;
        held_percent_next = held_percent_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;

        if (cmd.eval)
        begin
            if (co2_fault_reg)
            begin
                valve_open_next = 1'b0;
                closed_at_next  = now_reg;
            end
            else if (valve_open_reg)
            begin
                if (open_elapsed)
                begin
                    valve_open_next = 1'b0;
                    closed_at_next  = now_reg;
                end
            end
            else if (closed_elapsed)
            begin
                if (open_now)
                begin
                    valve_open_next = 1'b1;
                    opened_at_next  = now_reg;
                    if (duty_sum_reg < DUTY_W'(DUTY_WINDOW))
                        duty_sum_next = duty_sum_reg + 1'b1;
                end
                else
                begin
                    closed_at_next = now_reg;
                    if (duty_sum_reg != '0)
                        duty_sum_next = duty_sum_reg - 1'b1;
                end
                if (duty_count_reg < DUTY_W'(DUTY_WINDOW))
                    duty_count_next = duty_count_reg + 1'b1;
            end
            // dividend for the duty estimate, sum * 100
            rem_next = PROD_W'(duty_sum_next) * PROD_W'(PERCENT_SCALE);
            quo_next = '0;
        end

        if (cmd.div_step)
        begin
            if (div_hit)
                rem_next = rem_reg - trial;
            quo_next = quo_reg | (PCT_W'(div_hit) << cmd.div_bit);
            if (cmd.div_bit == '0)
                held_percent_next = quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valve_open_reg   <= 1'b0;
            opened_at_reg    <= '0;
            closed_at_reg    <= '0;
            duty_sum_reg     <= '0;
            duty_count_reg   <= '0;
            held_percent_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            valve_open_reg   <= valve_open_next;
            opened_at_reg    <= opened_at_next;
            closed_at_reg    <= closed_at_next;
            duty_sum_reg     <= duty_sum_next;
            duty_count_reg   <= duty_count_next;
            held_percent_reg <= held_percent_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.capture)
        begin
            now_reg        <= now_tick;
            co2_reg        <= co2_reading;
            co2_fault_reg  <= co2_fault;
            hum_reg        <= humidity_reading;
            hum_fault_reg  <= humidity_fault;
            temp_reg       <= temperature_reading;
            temp_fault_reg <= temperature_fault;
        end
        if (cmd.out_load)
        begin
            valve_drive        <= valve_open_reg;
            co2_report         <= co2_fault_reg ? FAULT_REPORT_CO2 : {1'b0, co2_reg};
            humidity_report    <= hum_fault_reg ? FAULT_REPORT_TH : {1'b0, hum_reg};
            temperature_report <= temp_fault_reg ? FAULT_REPORT_TH : temp_reg;
            valve_percent      <= held_percent_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_percent_reg <= PCT_W'(PERCENT_SCALE))
        else $error("duty percentage above full scale");

    a_sum_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        duty_sum_reg <= duty_count_reg)
        else $error("duty sum exceeds decision count");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        duty_count_reg <= DUTY_W'(DUTY_WINDOW))
        else $error("decision count past window");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// File: sv/co2_valve_duty_controller_unit.sv
// Top level of the CO2 valve duty controller: registers, sequencer and datapath.
//
// Usage
//   Input channel (in_valid/in_ready) carries one request: a sensor sample set with
//   its tick stamp. Output channel (out_valid/out_ready) returns one result per
//   request: valve drive, the three sensor reports and the held duty percentage.
//   Configuration goes through the APB port (target CO2 at 0x0, minimum open ticks
//   at 0x4, minimum closed ticks at 0x8); write only while no request is in flight.
// Timing
//   in_ready is high only in the idle state. A request that leads to an open/stay
//   shut decision runs a 7-step restoring divide for sum*100/count, one quotient
//   bit a cycle, before its result is loaded; any other request skips the divide
//   and goes from evaluation straight to the finish state.
// Stall
//   The result sits in an output register; the next request is still taken while
//   it waits. If the previous result is still untaken when a new one is ready, the
//   sequencer holds in its finish state and in_ready stays low until it is taken.
// Reset
//   rst_n is asynchronous, active low: valve closed, tick marks and duty estimate
//   cleared, registers back to target 0, open 2000, closed 10000, no result held.
`default_nettype none

module co2_valve_duty_controller_unit
    import cvdc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic      [DATA_W-1:0]        prdata,
    output logic                          pready,
    // request channel
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [TICK_W-1:0]        now_tick,
    input  wire logic [CO2_W-1:0]         co2_reading,
    input  wire logic                     co2_fault,
    input  wire logic [HUM_W-1:0]         humidity_reading,
    input  wire logic                     humidity_fault,
    input  wire logic signed [TEMP_W-1:0] temperature_reading,
    input  wire logic                     temperature_fault,
    // result channel
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          valve_drive,
    output logic signed [CO2_REP_W-1:0]   co2_report,
    output logic signed [TH_REP_W-1:0]    humidity_report,
    output logic signed [TH_REP_W-1:0]    temperature_report,
    output logic [PCT_W-1:0]              valve_percent
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    cvdc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: owns the request handshake and steps the datapath
    cvdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: timing marks, duty estimate, divider and the result register
    cvdc_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .cmd                 (cmd),
        .status              (status),
        .now_tick            (now_tick),
        .co2_reading         (co2_reading),
        .co2_fault           (co2_fault),
        .humidity_reading    (humidity_reading),
        .humidity_fault      (humidity_fault),
        .temperature_reading (temperature_reading),
        .temperature_fault   (temperature_fault),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .valve_drive         (valve_drive),
        .co2_report          (co2_report),
        .humidity_report     (humidity_report),
        .temperature_report  (temperature_report),
        .valve_percent       (valve_percent)
    );

endmodule

`default_nettype wire

// File: verif/co2_valve_duty_controller_unit_tb.sv
// Self-checking testbench for the CO2 valve duty controller: directed and random requests.
`default_nettype none

module co2_valve_duty_controller_unit_tb
    import cvdc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits. The watchdog allows several times the slowest legal run: ~1200 requests,
    // each with the longest sender gap, a decision with its divide, the longest result
    // stall, plus the long output hold and the register phases.
    localparam int          MAX_SHOWN        = 10;
    localparam int          DRAIN_CYCLES     = 16;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          MAX_PAUSE        = 13;
    localparam longint      WATCHDOG_NS      = 4_000_000;

    // One request as the sender sees it.
    typedef struct packed {
        logic [TICK_W-1:0] now;
        logic [CO2_W-1:0]  co2;
        logic              co2_flt;
        logic [HUM_W-1:0]  hum;
        logic              hum_flt;
        logic [TEMP_W-1:0] temp;
        logic              temp_flt;
    } sensor_sample_t;

    // One result, held as raw bit patterns at the port widths.
    typedef struct packed {
        logic                 valve;
        logic [CO2_REP_W-1:0] co2;
        logic [TH_REP_W-1:0]  hum;
        logic [TH_REP_W-1:0]  temp;
        logic [PCT_W-1:0]     pct;
    } valve_report_t;

    // ------------------------------------------------------------------ DUT signals
    logic                     clk     = 1'b0;
    logic                     rst_n   = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [ADDR_W-1:0]        paddr   = '0;
    logic [DATA_W-1:0]        pwdata  = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     in_valid            = 1'b0;
    logic                     in_ready;
    logic [TICK_W-1:0]        now_tick            = '0;
    logic [CO2_W-1:0]         co2_reading         = '0;
    logic                     co2_fault           = 1'b0;
    logic [HUM_W-1:0]         humidity_reading    = '0;
    logic                     humidity_fault      = 1'b0;
    logic signed [TEMP_W-1:0] temperature_reading = '0;
    logic                     temperature_fault   = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     valve_drive;
    logic signed [CO2_REP_W-1:0] co2_report;
    logic signed [TH_REP_W-1:0]  humidity_report;
    logic signed [TH_REP_W-1:0]  temperature_report;
    logic [PCT_W-1:0]            valve_percent;

    co2_valve_duty_controller_unit u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .now_tick            (now_tick),
        .co2_reading         (co2_reading),
        .co2_fault           (co2_fault),
        .humidity_reading    (humidity_reading),
        .humidity_fault      (humidity_fault),
        .temperature_reading (temperature_reading),
        .temperature_fault   (temperature_fault),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .valve_drive         (valve_drive),
        .co2_report          (co2_report),
        .humidity_report     (humidity_report),
        .temperature_report  (temperature_report),
        .valve_percent       (valve_percent)
    );

    // 8 ns clock period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------ shadow state
    // Register copy plus the valve/duty state the block should be carrying.
    cfg_t              cfg;
    logic              valve_open;
    logic [TICK_W-1:0] opened_tick;
    logic [TICK_W-1:0] closed_tick;
    int                duty_sum;
    int                duty_count;
    logic [PCT_W-1:0]  held_pct;

    valve_report_t     pending_reports[$];

    // Stimulus shaping shared between the sender and the result sink
    logic              sender_quiet      = 1'b0;
    logic              sink_quiet        = 1'b0;
    logic              long_hold_pending = 1'b0;
    logic [TICK_W-1:0] tick_cursor       = '0;

    // Tallies
    int mismatch_count  = 0;
    int reports_checked = 0;
    int samples_sent    = 0;
    int settings_used   = 0;
    int valve_openings  = 0;
    int stay_shut_calls = 0;
    int long_holds_done = 0;

    // Works out one result and moves the shadow state on. Tick distances are taken
    // modulo 2^32 simply by keeping them 32 bits wide.
    function automatic valve_report_t predict_valve_step(input sensor_sample_t s);
        valve_report_t     r;
        logic [TICK_W-1:0] open_for;
        logic [TICK_W-1:0] shut_for;
        logic              open_now;
        open_for = s.now - opened_tick;
        shut_for = s.now - closed_tick;
        if (s.co2_flt)
        begin
            // sensor fault: shut at once, no duty decision, percentage held
            valve_open  = 1'b0;
            closed_tick = s.now;
        end
        else if (valve_open)
        begin
            if (open_for >= cfg.min_open_ticks)
            begin
                valve_open  = 1'b0;
                closed_tick = s.now;
            end
        end
        else if (shut_for >= cfg.min_closed_ticks)
        begin
            open_now = s.co2 < cfg.co2_setpoint;
            if (open_now)
            begin
                valve_open  = 1'b1;
                opened_tick = s.now;
                valve_openings++;
                if (duty_sum < DUTY_WINDOW)
                    duty_sum++;
            end
            else
            begin
                // staying shut restarts the rest period
                closed_tick = s.now;
                stay_shut_calls++;
                if (duty_sum > 0)
                    duty_sum--;
            end
            if (duty_count < DUTY_WINDOW)
                duty_count++;
            held_pct = PCT_W'((duty_sum * PERCENT_SCALE) / duty_count);
        end
        r.valve = valve_open;
        r.co2   = s.co2_flt  ? FAULT_REPORT_CO2 : {1'b0, s.co2};
        r.hum   = s.hum_flt  ? FAULT_REPORT_TH  : {1'b0, s.hum};
        r.temp  = s.temp_flt ? FAULT_REPORT_TH  : s.temp;
        r.pct   = held_pct;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
                $display("MISMATCH %s (result %0d): expected 0x%0h, got 0x%0h",
                         field, reports_checked, want, got);
        end
    endtask

    // ------------------------------------------------------------------ result checker
    // Every accepted result is matched against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        valve_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("MISMATCH: result with no request outstanding");
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("valve_drive", 32'(want.valve), 32'(valve_drive));
                compare_field("co2_report", 32'(want.co2), 32'($unsigned(co2_report)));
                compare_field("humidity_report", 32'(want.hum),
                              32'($unsigned(humidity_report)));
                compare_field("temperature_report", 32'(want.temp),
                              32'($unsigned(temperature_report)));
                compare_field("valve_percent", 32'(want.pct), 32'(valve_percent));
            end
            reports_checked++;
        end
    end

    // ------------------------------------------------------------------ result sink
    // Random stall before each result; on request one long hold so the block backs up
    // and drops in_ready while the sender keeps offering.
    initial
    begin : result_sink
        int unsigned pause;
        int          held_cycles;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                out_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < LONG_HOLD_CYCLES; held_cycles++)
                    @(posedge clk);
                long_hold_pending = 1'b0;
                long_holds_done++;
            end
            pause = sink_quiet ? 0 : $urandom_range(0, MAX_PAUSE);
            if (pause != 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------ sender
    // Presents one request, waits for the handshake, records the prediction, then draws
    // the gap to the next one. With no gap valid stays high for the next request.
    task automatic send_sample(input sensor_sample_t s);
        int unsigned gap;
        in_valid            <= 1'b1;
        now_tick            <= s.now;
        co2_reading         <= s.co2;
        co2_fault           <= s.co2_flt;
        humidity_reading    <= s.hum;
        humidity_fault      <= s.hum_flt;
        temperature_reading <= s.temp;
        temperature_fault   <= s.temp_flt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_reports.push_back(predict_valve_step(s));
        samples_sent++;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_PAUSE);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic sensor_sample_t pack_sample(
        input logic [TICK_W-1:0] now, input logic [CO2_W-1:0] co2, input logic co2_flt,
        input logic [HUM_W-1:0] hum, input logic hum_flt,
        input logic [TEMP_W-1:0] temp, input logic temp_flt);
        sensor_sample_t s;
        s = '{now, co2, co2_flt, hum, hum_flt, temp, temp_flt};
        return s;
    endfunction

    // Drop valid, wait for every outstanding result, then let the sequencer settle.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB transfer: setup cycle, then access until pready. Read data taken at the
    // access edge.
    task automatic apb_transfer(input reg_idx_t idx, input logic wr,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input reg_idx_t idx, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        apb_transfer(idx, 1'b0, '0, got);
        compare_field(idx.name(), want, got);
    endtask

    // Idle the block, write all three registers and read each one back.
    task automatic apply_settings(input logic [CO2_W-1:0] target,
                                  input logic [TICK_W-1:0] open_ticks,
                                  input logic [TICK_W-1:0] closed_ticks);
        logic [DATA_W-1:0] unused;
        settle_block();
        apb_transfer(REG_CO2_SETPOINT, 1'b1, DATA_W'(target), unused);
        apb_transfer(REG_MIN_OPEN, 1'b1, open_ticks, unused);
        apb_transfer(REG_MIN_CLOSED, 1'b1, closed_ticks, unused);
        cfg.co2_setpoint     = target;
        cfg.min_open_ticks   = open_ticks;
        cfg.min_closed_ticks = closed_ticks;
        check_register(REG_CO2_SETPOINT, DATA_W'(target));
        check_register(REG_MIN_OPEN, open_ticks);
        check_register(REG_MIN_CLOSED, closed_ticks);
        settings_used++;
        @(posedge clk);
    endtask

    // Random requests: ticks creep forward by up to span (now and then jump anywhere),
    // CO2 mostly straddles the target so both decisions come up, faults are occasional.
    task automatic run_traffic(input int count, input logic [TICK_W-1:0] span);
        sensor_sample_t s;
        int             near;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                tick_cursor = $urandom;
            else
                tick_cursor += $urandom_range(0, span);
            s.now = tick_cursor;
            if ($urandom_range(0, 1) != 0)
            begin
                near  = int'(cfg.co2_setpoint) + int'($urandom_range(0, 600)) - 300;
                s.co2 = (near < 0) ? '0 : (near > 65535) ? '1 : CO2_W'(near);
            end
            else
                s.co2 = CO2_W'($urandom);
            s.co2_flt  = ($urandom_range(0, 9) == 0);
            s.hum      = HUM_W'($urandom);
            s.hum_flt  = ($urandom_range(0, 9) == 0);
            s.temp     = TEMP_W'($urandom);
            s.temp_flt = ($urandom_range(0, 9) == 0);
            send_sample(s);
        end
    endtask

    // ------------------------------------------------------------------ tests
    // Reset values of the registers, then requests under them: target 0 never opens,
    // the first decision only falls once 10000 ticks have passed.
    task automatic test_power_up_defaults();
        check_register(REG_CO2_SETPOINT, DATA_W'(TARGET_RESET));
        check_register(REG_MIN_OPEN, MIN_OPEN_RESET);
        check_register(REG_MIN_CLOSED, MIN_CLOSED_RESET);
        @(posedge clk);
        send_sample(pack_sample(32'd0,     16'd0,     1'b0, 15'd0,     1'b0, 16'h8000, 1'b0));
        send_sample(pack_sample(32'd9999,  16'd400,   1'b0, 15'h7FFF,  1'b0, 16'h7FFF, 1'b0));
        send_sample(pack_sample(32'd10000, 16'd0,     1'b0, 15'd123,   1'b0, 16'd0,    1'b0));
        send_sample(pack_sample(32'd10001, 16'd500,   1'b0, 15'h7FFF,  1'b1, 16'h8000, 1'b1));
        send_sample(pack_sample(32'd10002, 16'hFFFF,  1'b1, 15'd0,     1'b0, 16'hFFFF, 1'b0));
    endtask

    // Zero minimum times (always elapsed) and the top target: open, close, stay shut
    // at CO2 equal to target, CO2 fault while open, every fault flag at once.
    task automatic test_field_extremes();
        apply_settings(16'hFFFF, 32'd0, 32'd0);
        send_sample(pack_sample(32'd20000, 16'd0,     1'b0, 15'h4000, 1'b0, 16'h0001, 1'b0));
        send_sample(pack_sample(32'd20000, 16'hFFFF,  1'b0, 15'h2AAA, 1'b0, 16'hAAAA, 1'b0));
        send_sample(pack_sample(32'd20000, 16'hFFFF,  1'b0, 15'h5555, 1'b0, 16'h5555, 1'b0));
        send_sample(pack_sample(32'd20001, 16'hFFFE,  1'b0, 15'd1,    1'b0, 16'hFFFF, 1'b0));
        send_sample(pack_sample(32'd20002, 16'h8000,  1'b1, 15'd99,   1'b0, 16'd99,   1'b0));
        send_sample(pack_sample(32'hFFFFFFFF, 16'hFFFF, 1'b1, 15'h7FFF, 1'b1, 16'h7FFF, 1'b1));
        send_sample(pack_sample(32'd20003, 16'h8000,  1'b0, 15'h7FFF, 1'b0, 16'h8000, 1'b0));
    endtask

    // Tick counter wrapping through zero, distances one short of and exactly at the
    // minimum, and the widest minimum times met only by a distance of 2^32-1.
    task automatic test_tick_wrap();
        apply_settings(16'hFFFF, 32'd100, 32'd100);
        send_sample(pack_sample(32'hFFFFFFC0, 16'd10, 1'b0, 15'd1, 1'b0, 16'd1, 1'b0));
        send_sample(pack_sample(32'h00000010, 16'd10, 1'b0, 15'd2, 1'b0, 16'd2, 1'b0));
        send_sample(pack_sample(32'h00000024, 16'd10, 1'b0, 15'd3, 1'b0, 16'd3, 1'b0));
        send_sample(pack_sample(32'h00000087, 16'd10, 1'b0, 15'd4, 1'b0, 16'd4, 1'b0));
        send_sample(pack_sample(32'h00000088, 16'd10, 1'b0, 15'd5, 1'b0, 16'd5, 1'b0));
        apply_settings(16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_sample(pack_sample(32'h00000089, 16'd10, 1'b0, 15'd6, 1'b0, 16'd6, 1'b0));
        send_sample(pack_sample(32'h00000087, 16'd10, 1'b0, 15'd7, 1'b0, 16'd7, 1'b0));
        send_sample(pack_sample(32'h00000086, 16'd10, 1'b0, 15'd8, 1'b0, 16'd8, 1'b0));
    endtask

    // Enough decisions to saturate the decision count under the top target, then drive the duty estimate back to 0 %.
    task automatic test_duty_saturation();
        apply_settings(16'hFFFF, 32'd0, 32'd0);
        run_traffic(120, 32'd4);
        apply_settings(16'd0, 32'd0, 32'd0);
        run_traffic(120, 32'd4);
    endtask

    // Mixed random traffic over several register settings.
    task automatic test_random_traffic();
        logic [TICK_W-1:0] open_ticks;
        logic [TICK_W-1:0] closed_ticks;
        apply_settings(16'd1500, 32'd300, 32'd900);
        run_traffic(130, 32'd600);
        apply_settings(CO2_W'($urandom), MIN_OPEN_RESET, MIN_CLOSED_RESET);
        run_traffic(130, 32'd8000);
        for (int p = 0; p < 3; p++)
        begin
            open_ticks   = $urandom_range(0, 4000);
            closed_ticks = $urandom_range(0, 4000);
            apply_settings(CO2_W'($urandom), open_ticks, closed_ticks);
            run_traffic(130, open_ticks + closed_ticks + 32'd200);
        end
        // wide random thresholds with ticks anywhere
        apply_settings(CO2_W'($urandom), $urandom, $urandom);
        run_traffic(100, 32'hFFFFFFFF);
    endtask

    // Long output hold while the sender keeps going, so in_ready has to drop.
    task automatic test_output_backpressure();
        apply_settings(16'd40000, 32'd0, 32'd50);
        sender_quiet      = 1'b1;
        long_hold_pending = 1'b1;
        run_traffic(40, 32'd60);
        sender_quiet = 1'b0;
    endtask

    // Requests and results back to back with no idling on either side.
    task automatic test_back_to_back();
        apply_settings(16'd30000, 32'd5, 32'd20);
        sender_quiet = 1'b1;
        sink_quiet   = 1'b1;
        run_traffic(100, 32'd15);
        sender_quiet = 1'b0;
        sink_quiet   = 1'b0;
    endtask

    // ------------------------------------------------------------------ sequence
    initial
    begin
        cfg.co2_setpoint     = TARGET_RESET;
        cfg.min_open_ticks   = MIN_OPEN_RESET;
        cfg.min_closed_ticks = MIN_CLOSED_RESET;
        valve_open  = 1'b0;
        opened_tick = '0;
        closed_tick = '0;
        duty_sum    = 0;
        duty_count  = 0;
        held_pct    = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_defaults();
        test_field_extremes();
        test_tick_wrap();
        test_duty_saturation();
        test_random_traffic();
        test_output_backpressure();
        test_back_to_back();
        settle_block();

        $display("Covered %0d requests and %0d results over %0d register settings,",
                 samples_sent, reports_checked, settings_used);
        $display("with %0d valve openings, %0d stay-shut decisions and %0d long output hold.",
                 valve_openings, stay_shut_calls, long_holds_done);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #(WATCHDOG_NS);
        $display("Timed out with %0d results outstanding", pending_reports.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
